// File: sv/isa_pkg.sv
package isa_pkg;

	localparam int unsigned CORDIC_STEPS = 28;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef enum logic [2:0] {
		REG_GYRO_THR  = 3'd0,
		REG_ACCEL_THR = 3'd1,
		REG_TIMEOUT   = 3'd2,
		REG_PNOISE    = 3'd3,
		REG_MNOISE    = 3'd4,
		REG_INIT_COV  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TEST,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_ROLL,
		ST_PITCH,
		ST_PRED,
		ST_GAIN,
		ST_EST,
		ST_COV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic test;
		logic accept;
		logic start_div;
		logic start_sqrt;
		logic start_roll;
		logic start_pitch;
		logic pred;
		logic start_gain;
		logic est;
		logic start_cov;
	} cmd_t;

	typedef struct packed {
		logic aligned;
		logic stop;
		logic first;
		logic busy;
		logic s_zero;
	} sts_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		unique case (i)
			5'd0: r = 34'sd843314856;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043836;
			5'd3: r = 34'sd133525158;
			5'd4: r = 34'sd67021686;
			5'd5: r = 34'sd33543515;
			5'd6: r = 34'sd16775850;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194282;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			5'd24: r = 34'sd63;
			5'd25: r = 34'sd31;
			5'd26: r = 34'sd15;
			5'd27: r = 34'sd8;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/isa_if.sv
interface isa_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] gyro_x;
	logic signed [31:0] gyro_y;
	logic signed [31:0] gyro_z;
	logic signed [31:0] accel_x;
	logic signed [31:0] accel_y;
	logic signed [31:0] accel_z;
	modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		input ready);
	modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		output ready);
endinterface

interface isa_out_if;
	logic valid;
	logic ready;
	logic stop_reason;
	logic signed [18:0] roll_angle;
	logic signed [18:0] pitch_angle;
	logic signed [31:0] bias_gx;
	logic signed [31:0] bias_gy;
	logic signed [31:0] bias_gz;
	logic signed [31:0] mean_ax;
	logic signed [31:0] mean_ay;
	logic signed [31:0] mean_az;
	modport source (output valid, stop_reason, roll_angle, pitch_angle, bias_gx, bias_gy,
		bias_gz, mean_ax, mean_ay, mean_az, input ready);
	modport sink (input valid, stop_reason, roll_angle, pitch_angle, bias_gx, bias_gy,
		bias_gz, mean_ax, mean_ay, mean_az, output ready);
endinterface

interface isa_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/isa_ctrl.sv
module isa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  isa_pkg::sts_t    sts,
	output isa_pkg::cmd_t    cmd
);
	isa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			isa_pkg::ST_IDLE: begin
				// covariance division of the last sample may still be running
				in_ready = !sts.busy;
				if (in_valid && !sts.busy) begin
					cmd.load = 1'b1;
					state_d = sts.aligned ? isa_pkg::ST_OUT : isa_pkg::ST_TEST;
				end
			end
			isa_pkg::ST_TEST: begin
				cmd.test = 1'b1;
				state_d = sts.stop ? isa_pkg::ST_IDLE : isa_pkg::ST_ACC;
			end
			isa_pkg::ST_ACC: begin
				cmd.accept = 1'b1;
				state_d = isa_pkg::ST_DIV;
			end
			isa_pkg::ST_DIV: begin
				cmd.start_div = 1'b1;
				state_d = isa_pkg::ST_SQRT;
			end
			isa_pkg::ST_SQRT: begin
				if (!sts.busy) begin
					cmd.start_sqrt = 1'b1;
					state_d = isa_pkg::ST_ROLL;
				end
			end
			isa_pkg::ST_ROLL: begin
				if (!sts.busy) begin
					cmd.start_roll = 1'b1;
					state_d = isa_pkg::ST_PITCH;
				end
			end
			isa_pkg::ST_PITCH: begin
				if (!sts.busy) begin
					cmd.start_pitch = 1'b1;
					state_d = isa_pkg::ST_PRED;
				end
			end
			isa_pkg::ST_PRED: begin
				if (!sts.busy) begin
					cmd.pred = 1'b1;
					state_d = isa_pkg::ST_GAIN;
				end
			end
			isa_pkg::ST_GAIN: begin
				if (sts.s_zero) begin
					state_d = isa_pkg::ST_IDLE;
				end else begin
					cmd.start_gain = 1'b1;
					state_d = isa_pkg::ST_EST;
				end
			end
			isa_pkg::ST_EST: begin
				if (!sts.busy) begin
					cmd.est = 1'b1;
					state_d = isa_pkg::ST_COV;
				end
			end
			isa_pkg::ST_COV: begin
				cmd.start_cov = 1'b1;
				state_d = isa_pkg::ST_IDLE;
			end
			isa_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = isa_pkg::ST_IDLE;
			end
			default: state_d = isa_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: sv/isa_dp.sv
module isa_dp #(
	parameter int MAX_SAMPLES = 65536,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  isa_pkg::cmd_t     cmd,
	output isa_pkg::sts_t     sts,
	input  logic              idle,
	input  logic [191:0]      smp_in,
	input  logic [15:0]       gyro_thr,
	input  logic [19:0]       accel_thr,
	input  logic [15:0]       timeout,
	input  logic [22:0]       pnoise,
	input  logic [22:0]       mnoise,
	input  logic [30:0]       init_cov,
	input  logic              cov_reload,
	output logic              reason,
	output logic signed [18:0] roll_o,
	output logic signed [18:0] pitch_o,
	output logic [191:0]      means_o
);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic signed [47:0] sums_q [6];
	logic signed [31:0] means_q [6];
	logic signed [31:0] last_q [6];
	logic signed [31:0] smp_q [6];
	logic [CW-1:0] cnt_q;
	logic signed [31:0] roll_q, pitch_q;
	logic [31:0] cov_q;
	logic aligned_q, reason_q;
	logic signed [31:0] mroll_q, mpitch_q;

	// shared iterative unit: modes
	typedef enum logic [2:0] {M_NONE, M_MDIV, M_SQRT, M_ATAN, M_GAIN, M_COV} mode_t;
	mode_t mode_q;
	logic [6:0] step_q;
	logic [2:0] axis_q;
	logic [5:0] pass_q;
	// divider regs
	logic [63:0] num_q;
	logic [47:0] den_q;
	logic [48:0] rem_q;
	logic [63:0] quo_q;
	logic neg_q;
	// sqrt regs
	logic [63:0] sn_q, sres_q, sbit_q;
	logic [31:0] horiz_q;
	// cordic regs
	logic signed [34:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic pitch_sel_q;
	logic [31:0] k_q;
	logic [31:0] p_q;

	logic moved;
	logic timed_out;

	always_comb begin
		moved = 1'b0;
		for (int i = 0; i < 6; i++) begin
			logic signed [32:0] d;
			logic [32:0] a;
			d = 33'(last_q[i]) - 33'(means_q[i]);
			a = d[32] ? 33'(-d) : d;
			if (a > (i < 3 ? 33'(gyro_thr) : 33'(accel_thr))) moved = 1'b1;
		end
		if (cnt_q == '0) moved = 1'b0;
		timed_out = (32'(cnt_q) > 32'(timeout)) || (32'(cnt_q) >= 32'(MAX_SAMPLES));
	end

	// prediction and S
	logic [32:0] p_pred;
	logic [33:0] s_sum;
	logic [31:0] p_sat;
	always_comb begin
		p_pred = 33'(cov_q) + 33'(pnoise);
		p_sat = p_pred[32] ? 32'hFFFF_FFFF : p_pred[31:0];
		s_sum = 34'(p_q) + 34'(mnoise);
	end

	// Kalman estimate update
	function automatic logic signed [31:0] kupd(input logic signed [31:0] est,
		input logic signed [31:0] meas, input logic [31:0] k);
		logic signed [33:0] d;
		logic signed [66:0] pr;
		logic [66:0] mag;
		logic [66:0] r;
		logic signed [66:0] rr;
		d = 34'(meas) - 34'(est);
		pr = 67'(d) * $signed({35'd0, k});
		mag = pr[66] ? 67'(-pr) : 67'(pr);
		r = (mag + (67'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		rr = pr[66] ? -$signed(r) : $signed(r);
		return est + 32'(rr);
	endfunction

	// cordic helpers
	logic signed [34:0] xs, ys;
	assign xs = cx_q >>> step_q[4:0];
	assign ys = cy_q >>> step_q[4:0];

	logic [33:0] zmag;
	logic [33:0] zrnd;
	logic signed [31:0] zfin;
	always_comb begin
		zmag = cz_q[33] ? 34'(-cz_q) : 34'(cz_q);
		zrnd = (zmag + (34'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
		zfin = cz_q[33] ? -$signed(32'(zrnd)) : $signed(32'(zrnd));
	end

	// divider step (restoring)
	logic [48:0] rem_sh;
	logic [48:0] rem_sub;
	assign rem_sh = {rem_q[47:0], num_q[63]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				sums_q[i] <= '0;
				means_q[i] <= '0;
				last_q[i] <= '0;
			end
			cnt_q <= '0;
			roll_q <= '0;
			pitch_q <= '0;
			cov_q <= 32'd6553600;
			aligned_q <= 1'b0;
			reason_q <= 1'b0;
			mode_q <= M_NONE;
		end else begin
			if (cov_reload && idle && cnt_q == '0) cov_q <= 32'(init_cov);
			if (cmd.load) begin
				for (int i = 0; i < 6; i++) smp_q[i] <= smp_in[i*32 +: 32];
			end
			if (cmd.test) begin
				if (timed_out || moved) begin
					aligned_q <= 1'b1;
					reason_q <= timed_out;
				end
			end
			if (cmd.accept) begin
				if (cnt_q == '0) cov_q <= 32'(init_cov);
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < 6; i++) begin
					last_q[i] <= smp_q[i];
					sums_q[i] <= sums_q[i] + 48'(smp_q[i]);
				end
			end
			if (cmd.start_div) begin
				mode_q <= M_MDIV;
				axis_q <= '0;
				step_q <= '0;
				neg_q <= sums_q[0][47];
				num_q <= {sums_q[0][47] ? 48'(-sums_q[0]) : 48'(sums_q[0]), 16'd0};
				den_q <= 48'(cnt_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			if (cmd.start_sqrt) begin
				mode_q <= M_SQRT;
				sn_q <= 64'(64'(means_q[4]) * 64'(means_q[4]))
					+ 64'(64'(means_q[5]) * 64'(means_q[5]));
				sres_q <= '0;
				sbit_q <= 64'd1 << 62;
			end
			if (cmd.start_roll || cmd.start_pitch) begin
				logic signed [34:0] x0, y0;
				mode_q <= M_ATAN;
				step_q <= '0;
				pitch_sel_q <= cmd.start_pitch;
				if (cmd.start_roll) begin
					x0 = 35'(means_q[5]);
					y0 = 35'(means_q[4]);
				end else begin
					x0 = 35'(horiz_q);
					y0 = -35'(means_q[3]);
				end
				if (x0 < 0) begin
					if (y0 >= 0) begin
						cx_q <= y0; cy_q <= -x0; cz_q <= isa_pkg::HALF_PI_Q30;
					end else begin
						cx_q <= -y0; cy_q <= x0; cz_q <= -isa_pkg::HALF_PI_Q30;
					end
				end else begin
					cx_q <= x0; cy_q <= y0; cz_q <= '0;
				end
				pass_q <= (x0 == 0 && y0 == 0) ? 6'd1 : 6'd0;
			end
			// predicted covariance is kept when S is zero, else replaced below
			if (cmd.pred) begin
				p_q <= p_sat;
				cov_q <= p_sat;
			end
			if (cmd.start_gain) begin
				mode_q <= M_GAIN;
				step_q <= '0;
				num_q <= {p_q, 32'd0} >> (32 - FRAC_BITS);
				den_q <= 48'(s_sum);
				rem_q <= '0;
				quo_q <= '0;
			end
			if (cmd.est) begin
				roll_q <= kupd(roll_q, mroll_q, k_q);
				pitch_q <= kupd(pitch_q, mpitch_q, k_q);
			end
			if (cmd.start_cov) begin
				mode_q <= M_COV;
				step_q <= '0;
				num_q <= 64'(p_q) * 64'(mnoise);
				den_q <= 48'(s_sum);
				rem_q <= '0;
				quo_q <= '0;
			end
			unique case (mode_q)
				M_MDIV, M_GAIN, M_COV: begin
					num_q <= num_q << 1;
					if (!rem_sub[48]) begin
						rem_q <= rem_sub;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (mode_q == M_MDIV && step_q == 7'd47) begin
						logic [47:0] q;
						q = {quo_q[46:0], ~rem_sub[48]};
						means_q[axis_q] <= neg_q ? -32'(q) : 32'(q);
						if (axis_q == 3'd5) begin
							mode_q <= M_NONE;
						end else begin
							axis_q <= axis_q + 1'b1;
							step_q <= '0;
							neg_q <= sums_q[axis_q + 1'b1][47];
							num_q <= {sums_q[axis_q + 1'b1][47] ? 48'(-sums_q[axis_q + 1'b1])
								: 48'(sums_q[axis_q + 1'b1]), 16'd0};
							rem_q <= '0;
							quo_q <= '0;
						end
					end
					if (mode_q != M_MDIV && step_q == 7'd63) begin
						logic [63:0] q;
						q = {quo_q[62:0], ~rem_sub[48]};
						mode_q <= M_NONE;
						if (mode_q == M_GAIN) k_q <= q[31:0];
						else cov_q <= q[31:0];
					end
				end
				M_SQRT: begin
					if (sbit_q == '0) begin
						horiz_q <= sres_q[31:0];
						mode_q <= M_NONE;
					end else begin
						if (sbit_q > sn_q && sres_q == '0) begin
							sbit_q <= sbit_q >> 2;
						end else if (sn_q >= sres_q + sbit_q) begin
							sn_q <= sn_q - (sres_q + sbit_q);
							sres_q <= (sres_q >> 1) + sbit_q;
							sbit_q <= sbit_q >> 2;
						end else begin
							sres_q <= sres_q >> 1;
							sbit_q <= sbit_q >> 2;
						end
					end
				end
				M_ATAN: begin
					if (pass_q[0] || step_q == 7'(isa_pkg::CORDIC_STEPS)) begin
						mode_q <= M_NONE;
						if (pitch_sel_q) mpitch_q <= pass_q[0] ? '0 : zfin;
						else mroll_q <= pass_q[0] ? '0 : zfin;
					end else begin
						if (cy_q > 0) begin
							cx_q <= cx_q + ys; cy_q <= cy_q - xs;
							cz_q <= cz_q + isa_pkg::atan_q30(step_q[4:0]);
						end else begin
							cx_q <= cx_q - ys; cy_q <= cy_q + xs;
							cz_q <= cz_q - isa_pkg::atan_q30(step_q[4:0]);
						end
						step_q <= step_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		sts.aligned = aligned_q;
		sts.stop = timed_out || moved;
		sts.first = (cnt_q == '0);
		sts.busy = (mode_q != M_NONE);
		sts.s_zero = (s_sum == '0);
		reason = reason_q;
		roll_o = roll_q[18:0];
		pitch_o = pitch_q[18:0];
		for (int i = 0; i < 6; i++) means_o[i*32 +: 32] = means_q[i];
	end
endmodule

// File: sv/imu_static_alignment_unit.sv
// IMU static alignment unit.
// Samples arrive on in_ch (six Q16.16 axes). While the unit is still aligning,
// each request is tested for motion/timeout and, if kept, folded into the sums,
// means, atan2 levelling and scalar Kalman filter; it yields no result.
// Once alignment has ended every request yields one result on out_ch holding
// stop reason, roll, pitch, gyro bias and mean accel.
// A kept sample occupies the unit for six mean divisions, a square root, two
// CORDIC passes (cut short when both atan2 inputs are zero) and two divisions,
// all on one shared iterative unit; in_ch is ready only when that work is done.
// A sample that ends alignment is dropped in the test state and yields no
// result. After alignment a result is valid the cycle after the request and
// holds until taken, and no new request is taken until then; a stalled
// receiver holds off in_ch.
// Reset (arst_n low) clears sums, count and estimates, restores register
// defaults and loads covariance with the default initial covariance.
// cfg_ch writes registers by index; it is always ready and must be written
// only while idle.
module imu_static_alignment_unit #(
	parameter int MAX_SAMPLES = 65536,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	isa_in_if.sink    in_ch,
	isa_out_if.source out_ch,
	isa_cfg_if.sink   cfg_ch
);
	logic [15:0] gyro_thr_q;
	logic [19:0] accel_thr_q;
	logic [15:0] timeout_q;
	logic [22:0] pnoise_q;
	logic [22:0] mnoise_q;
	logic [30:0] init_cov_q;
	logic cov_wr;

	assign cfg_ch.ready = 1'b1;
	assign cov_wr = cfg_ch.valid && cfg_ch.index == 3'(isa_pkg::REG_INIT_COV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_thr_q <= 16'd1966;
			accel_thr_q <= 20'd13107;
			timeout_q <= 16'd12000;
			pnoise_q <= 23'd6554;
			mnoise_q <= 23'd6554;
			init_cov_q <= 31'd6553600;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				3'(isa_pkg::REG_GYRO_THR): gyro_thr_q <= cfg_ch.data[15:0];
				3'(isa_pkg::REG_ACCEL_THR): accel_thr_q <= cfg_ch.data[19:0];
				3'(isa_pkg::REG_TIMEOUT): timeout_q <= cfg_ch.data[15:0];
				3'(isa_pkg::REG_PNOISE): pnoise_q <= cfg_ch.data[22:0];
				3'(isa_pkg::REG_MNOISE): mnoise_q <= cfg_ch.data[22:0];
				3'(isa_pkg::REG_INIT_COV): init_cov_q <= cfg_ch.data[30:0];
				default: ;
			endcase
		end
	end

	isa_pkg::cmd_t cmd;
	isa_pkg::sts_t sts;
	logic rdy;

	isa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(rdy),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);
	assign in_ch.ready = rdy;

	logic [191:0] means;
	// covariance before the first sample is reloaded at accept time anyway
	isa_dp #(.MAX_SAMPLES(MAX_SAMPLES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .idle(rdy),
		.smp_in({in_ch.accel_z, in_ch.accel_y, in_ch.accel_x,
			in_ch.gyro_z, in_ch.gyro_y, in_ch.gyro_x}),
		.gyro_thr(gyro_thr_q), .accel_thr(accel_thr_q), .timeout(timeout_q),
		.pnoise(pnoise_q), .mnoise(mnoise_q), .init_cov(init_cov_q),
		.cov_reload(cov_wr),
		.reason(out_ch.stop_reason), .roll_o(out_ch.roll_angle),
		.pitch_o(out_ch.pitch_angle), .means_o(means)
	);

	assign out_ch.bias_gx = means[31:0];
	assign out_ch.bias_gy = means[63:32];
	assign out_ch.bias_gz = means[95:64];
	assign out_ch.mean_ax = means[127:96];
	assign out_ch.mean_ay = means[159:128];
	assign out_ch.mean_az = means[191:160];
endmodule

// File: verif/isa_checker.sv
// Watches the sample, result and register channels, tracks the levelling
// state on its own and compares every result with the oldest expected one.
module isa_checker (
	input  logic clk,
	input  logic arst_n,
	isa_in_if    in_ch,
	isa_out_if   out_ch,
	isa_cfg_if   cfg_ch,
	output int   fail_count,
	output int   pending,
	output int   kept_count,
	output int   result_count,
	output logic timed_out_end
);

	typedef struct {
		logic        stop;
		logic [18:0] roll;
		logic [18:0] pitch;
		logic [31:0] mean[6];
	} level_result_t;

	localparam longint ATAN_TBL[isa_pkg::CORDIC_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 8
	};

	level_result_t result_q[$];

	longint      sums[6];
	longint      means[6];
	longint      last_smp[6];
	int unsigned n_kept;
	longint      roll_q;
	longint      pitch_q;
	logic [63:0] cov;
	bit          aligned;
	bit          by_timeout;
	logic [31:0] gyro_thr, accel_thr, tmo_lim, q_noise, r_noise, cov_init;

	function automatic longint round_away(longint v, int s);
		logic [63:0] mag;
		longint      r;
		mag = (v < 0) ? -v : v;
		r = longint'((mag + (64'd1 << (s - 1))) >> s);
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint cordic_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = isa_pkg::HALF_PI_Q30;
			end else begin
				t = x; x = -y; y = t; z = -isa_pkg::HALF_PI_Q30;
			end
		end
		for (int i = 0; i < isa_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys; y -= xs; z += ATAN_TBL[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_TBL[i];
			end
		end
		return round_away(z, 14);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void load_defaults();
		gyro_thr  = 1966;
		accel_thr = 13107;
		tmo_lim   = 12000;
		q_noise   = 6554;
		r_noise   = 6554;
		cov_init  = 6553600;
		foreach (sums[i]) begin
			sums[i] = 0; means[i] = 0; last_smp[i] = 0;
		end
		n_kept = 0;
		roll_q = 0;
		pitch_q = 0;
		cov = cov_init;
		aligned = 0;
		by_timeout = 0;
	endfunction

	// scalar filter shared by roll and pitch
	function automatic void filter_update(longint z_roll, longint z_pitch);
		logic [63:0] p, s, k;
		p = cov + q_noise;
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		s = p + r_noise;
		if (s == 0) begin
			cov = p;
			return;
		end
		k = (p << 16) / s;
		roll_q += round_away((z_roll - roll_q) * longint'(k), 16);
		pitch_q += round_away((z_pitch - pitch_q) * longint'(k), 16);
		cov = (p * r_noise) / s;
	endfunction

	function automatic void level_sample(longint smp[6]);
		bit          tmo, moved;
		longint      d, ax, ay, az, horiz;
		logic [63:0] lim, mag2;
		level_result_t r;
		if (aligned) begin
			r.stop = by_timeout;
			r.roll = roll_q[18:0];
			r.pitch = pitch_q[18:0];
			foreach (r.mean[i])
				r.mean[i] = means[i][31:0];
			result_q = {result_q, r};
			return;
		end
		tmo = (n_kept > tmo_lim) || (n_kept >= 65536);
		moved = 0;
		if (n_kept > 0) begin
			for (int i = 0; i < 6; i++) begin
				d = last_smp[i] - means[i];
				lim = (i < 3) ? gyro_thr : accel_thr;
				if (d < 0)
					d = -d;
				if (d > lim)
					moved = 1;
			end
		end
		if (tmo || moved) begin
			aligned = 1;
			by_timeout = tmo;
			return;
		end
		if (n_kept == 0)
			cov = cov_init;
		n_kept++;
		for (int i = 0; i < 6; i++) begin
			last_smp[i] = smp[i];
			sums[i] += smp[i];
			means[i] = sums[i] / longint'(n_kept);
		end
		ax = means[3];
		ay = means[4];
		az = means[5];
		mag2 = (ay * ay) + (az * az);
		horiz = longint'(floor_sqrt(mag2));
		filter_update(cordic_angle(ay, az), cordic_angle(-ax, horiz));
	endfunction

	function automatic void check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint        smp[6];
		longint        obs[6];
		level_result_t r;
		if (!arst_n) begin
			load_defaults();
			result_q.delete();
			fail_count = 0;
			kept_count = 0;
			result_count = 0;
			pending = 0;
			timed_out_end = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				unique case (isa_pkg::reg_idx_t'(cfg_ch.index))
					isa_pkg::REG_GYRO_THR:  gyro_thr  = cfg_ch.data[15:0];
					isa_pkg::REG_ACCEL_THR: accel_thr = cfg_ch.data[19:0];
					isa_pkg::REG_TIMEOUT:   tmo_lim   = cfg_ch.data[15:0];
					isa_pkg::REG_PNOISE:    q_noise   = cfg_ch.data[22:0];
					isa_pkg::REG_MNOISE:    r_noise   = cfg_ch.data[22:0];
					isa_pkg::REG_INIT_COV:  cov_init  = cfg_ch.data[30:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				smp[0] = in_ch.gyro_x;
				smp[1] = in_ch.gyro_y;
				smp[2] = in_ch.gyro_z;
				smp[3] = in_ch.accel_x;
				smp[4] = in_ch.accel_y;
				smp[5] = in_ch.accel_z;
				level_sample(smp);
			end
			if (out_ch.valid && out_ch.ready) begin
				result_count++;
				if (result_q.size() == 0) begin
					$error("result with no request waiting for one");
					fail_count++;
				end else begin
					r = result_q.pop_front();
					obs = '{out_ch.bias_gx, out_ch.bias_gy, out_ch.bias_gz,
						out_ch.mean_ax, out_ch.mean_ay, out_ch.mean_az};
					check_field("stop_reason", r.stop, out_ch.stop_reason);
					check_field("roll_angle", r.roll, out_ch.roll_angle[18:0]);
					check_field("pitch_angle", r.pitch, out_ch.pitch_angle[18:0]);
					check_field("bias_gx", r.mean[0], obs[0][31:0]);
					check_field("bias_gy", r.mean[1], obs[1][31:0]);
					check_field("bias_gz", r.mean[2], obs[2][31:0]);
					check_field("mean_ax", r.mean[3], obs[3][31:0]);
					check_field("mean_ay", r.mean[4], obs[4][31:0]);
					check_field("mean_az", r.mean[5], obs[5][31:0]);
				end
			end
			pending = result_q.size();
			kept_count = n_kept;
			timed_out_end = by_timeout;
		end
	end

endmodule

// File: verif/imu_static_alignment_unit_tb.sv
// Testbench top: drives samples and register writes, stalls the result side,
// and reports the verdict. All prediction lives in isa_checker.
module imu_static_alignment_unit_tb;

	localparam int N_ITEMS  = 1400;
	localparam int WDOG_MAX = 20000;	// covers the slowest sample plus long gaps
	localparam int SETTLE   = 600;	// a kept sample may still be in flight

	logic clk;
	logic arst_n;

	isa_in_if  in_ch();
	isa_out_if out_ch();
	isa_cfg_if cfg_ch();

	int   fail_count, pending, kept_count, result_count;
	logic timed_out_end;

	int sent;
	int out_stall;
	int wdog;
	bit quiet;	// stretch with no idling on either side
	int gyro_base[3];
	int accel_base[3];

	imu_static_alignment_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	isa_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.cfg_ch        (cfg_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.kept_count    (kept_count),
		.result_count  (result_count),
		.timed_out_end (timed_out_end)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic int jitter(int base, int amp);
		return base + $urandom_range(0, 2 * amp) - amp;
	endfunction

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_stall <= 0;
		end else if (out_stall != 0) begin
			out_ch.ready <= 1'b0;
			out_stall <= out_stall - 1;
		end else begin
			out_ch.ready <= 1'b1;
			out_stall <= gap_len();
		end
	end

	// watchdog: cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			wdog <= 0;
		end else if (wdog >= WDOG_MAX) begin
			$display("Verification failed");
			$finish;
		end else begin
			wdog <= wdog + 1;
		end
	end

	task automatic send_sample(int gx, int gy, int gz, int ax, int ay, int az);
		int g;
		g = gap_len();
		quiet = ((sent / 64) % 5) == 4;
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.gyro_x  <= gx;
		in_ch.gyro_y  <= gy;
		in_ch.gyro_z  <= gz;
		in_ch.accel_x <= ax;
		in_ch.accel_y <= ay;
		in_ch.accel_z <= az;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
	endtask

	// still IMU: base vector plus small noise
	task automatic send_still(int g_amp, int a_amp);
		send_sample(jitter(gyro_base[0], g_amp), jitter(gyro_base[1], g_amp),
			jitter(gyro_base[2], g_amp), jitter(accel_base[0], a_amp),
			jitter(accel_base[1], a_amp), jitter(accel_base[2], a_amp));
	endtask

	task automatic write_reg(isa_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// registers change only with no request in flight
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		in_ch.valid   <= 1'b0;
		in_ch.gyro_x  <= '0;
		in_ch.gyro_y  <= '0;
		in_ch.gyro_z  <= '0;
		in_ch.accel_x <= '0;
		in_ch.accel_y <= '0;
		in_ch.accel_z <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= isa_pkg::REG_GYRO_THR;
		cfg_ch.data   <= '0;
		sent = 0;
		quiet = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base attitude: accel small enough that the settling transient
		// stays under the widest threshold; signs random so every quadrant
		// of the angle pre-rotation can show up
		foreach (gyro_base[i])
			gyro_base[i] = $urandom_range(0, 60000) - 30000;
		foreach (accel_base[i])
			accel_base[i] = $urandom_range(0, 600000) - 300000;

		// widest gyro threshold and timeout, wide accel threshold, slow filter, largest start covariance
		write_reg(isa_pkg::REG_GYRO_THR, 32'd65535);
		write_reg(isa_pkg::REG_ACCEL_THR, 32'd655360);
		write_reg(isa_pkg::REG_TIMEOUT, 32'd65535);
		write_reg(isa_pkg::REG_PNOISE, 32'd1);
		write_reg(isa_pkg::REG_MNOISE, 32'd6553600);
		write_reg(isa_pkg::REG_INIT_COV, 32'd2147483647);
		cfg_ch.valid <= 1'b0;

		// directed: all-zero first sample (atan2 of zero), exact base, one noisy
		// sample, one noise-free sample, then the usual stream
		send_sample(0, 0, 0, 0, 0, 0);
		send_sample(gyro_base[0], gyro_base[1], gyro_base[2],
			accel_base[0], accel_base[1], accel_base[2]);
		send_still(400, 2000);
		send_still(0, 0);
		repeat (146) send_still(400, 2000);

		// fast filter, default thresholds
		wait_idle();
		write_reg(isa_pkg::REG_PNOISE, 32'd6553600);
		write_reg(isa_pkg::REG_MNOISE, 32'd1);
		write_reg(isa_pkg::REG_GYRO_THR, 32'd1966);
		write_reg(isa_pkg::REG_ACCEL_THR, 32'd13107);
		cfg_ch.valid <= 1'b0;
		repeat (200) send_still(400, 2000);

		// balanced filter; start covariance only matters on a first sample
		wait_idle();
		write_reg(isa_pkg::REG_PNOISE, 32'd6554);
		write_reg(isa_pkg::REG_MNOISE, 32'd6554);
		write_reg(isa_pkg::REG_INIT_COV, 32'd1);
		write_reg(isa_pkg::REG_GYRO_THR, 32'd4000);
		write_reg(isa_pkg::REG_ACCEL_THR, 32'd20000);
		cfg_ch.valid <= 1'b0;
		repeat (250) send_still(400, 2000);

		// end alignment: either by the sample limit or by a violent sample
		wait_idle();
		if ($urandom_range(0, 1) == 1) begin
			write_reg(isa_pkg::REG_TIMEOUT, 32'd1);
			write_reg(isa_pkg::REG_GYRO_THR, 32'd0);	// both trip, timeout must win
			cfg_ch.valid <= 1'b0;
			send_still(400, 2000);
		end else begin
			// extreme sample is kept, the next one sees the jump
			send_sample(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000,
				32'h7FFF_FFFF, 32'h8000_0000);
			send_still(400, 2000);
		end

		// aligned now: registers no longer matter, write zero thresholds and a timeout of 1
		wait_idle();
		write_reg(isa_pkg::REG_ACCEL_THR, 32'd0);
		write_reg(isa_pkg::REG_GYRO_THR, 32'd0);
		write_reg(isa_pkg::REG_TIMEOUT, 32'd1);
		cfg_ch.valid <= 1'b0;

		// frozen results for any input, full-range content
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		while (sent < N_ITEMS)
			send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d samples, %0d kept before alignment stopped by %s.",
			sent, kept_count, timed_out_end ? "timeout" : "motion");
		$display("Checked %0d frozen alignment results field by field.", result_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
